### rtl/core/atl_pkg.sv
// Shared types, token codes and byte classification for the ASCII token lexer.
package atl_pkg;

    // Token kinds reported on token_kind
    localparam logic [4:0] KIND_SYMBOL      = 5'd0;
    localparam logic [4:0] KIND_INTEGER     = 5'd1;
    localparam logic [4:0] KIND_WHITESPACE  = 5'd2;
    localparam logic [4:0] KIND_PUNCT_BASE  = 5'd3;
    localparam logic [4:0] KIND_ERROR       = 5'd26;
    localparam logic [4:0] KIND_END         = 5'd27;

    // Open run codes held by the front end
    localparam logic [1:0] RUN_NONE         = 2'd0;
    localparam logic [1:0] RUN_SYMBOL       = 2'd1;
    localparam logic [1:0] RUN_INTEGER      = 2'd2;
    localparam logic [1:0] RUN_WHITESPACE   = 2'd3;

    // Position saturation limit: min(MAX_LEN, 65535)
    localparam logic [31:0] MAX_LEN   = 32'd65535;
    localparam logic [15:0] POS_LIMIT =
        (MAX_LEN < 32'd65535) ? MAX_LEN[15:0] : 16'hFFFF;

    // Default depth of the front-to-back token queue
    localparam int QUEUE_DEPTH = 4;

    localparam int PUNCT_COUNT = 23;
    localparam logic [7:0] PUNCT_BYTES [PUNCT_COUNT] = '{
        8'h3A, 8'h2C, 8'h2E, 8'h2D, 8'h2F, 8'h3D, 8'h23, 8'h40,
        8'h21, 8'h25, 8'h2A, 8'h2B, 8'h3F, 8'h26, 8'h7E, 8'h5B,
        8'h5D, 8'h24, 8'h3B, 8'h28, 8'h29, 8'h27, 8'h22
    };

    // One queue entry: an optional run token followed by an optional own token
    typedef struct packed {
        logic        run_vld;
        logic [1:0]  run_code;
        logic [15:0] run_start;
        logic [15:0] run_len;
        logic        own_vld;
        logic [4:0]  own_kind;
        logic [15:0] own_start;
    } atl_entry_t;

    // Map a byte to its token kind: run classes, punctuation or error
    function automatic logic [4:0] classify(input logic [7:0] b);
        logic [4:0] kind;
        kind = KIND_ERROR;
        case (b) inside
            [8'h61:8'h7A], [8'h41:8'h5A], 8'h5F:
                kind = KIND_SYMBOL;
            [8'h30:8'h39]:
                kind = KIND_INTEGER;
            8'h20, 8'h0C, 8'h0A, 8'h0D, 8'h09, 8'h0B:
                kind = KIND_WHITESPACE;
            default:
            begin
                for (int i = 0; i < PUNCT_COUNT; i++)
                begin
                    if (PUNCT_BYTES[i] == b)
                    begin
                        kind = KIND_PUNCT_BASE + 5'(i);
                    end
                end
            end
        endcase
        return kind;
    endfunction

endpackage

### rtl/core/ascii_token_lexer_unit.sv
// Top level of the ASCII token lexer: front end, token queue and back end.
//
//  channel  | transaction when       | payload
//  ---------+------------------------+-------------------------------------------------
//  input    | push && !full          | byte_value, end_of_input
//  result   | pop && !empty          | token_kind, start_pos, token_length, last_result
//
// One byte is taken per cycle while full is low; the front end classifies it in the
// cycle it is taken. Each result passes through the queue, then the result register;
// the back end sends one token per cycle while pop is high, so the two tokens of an
// item go out in turn, which the queue absorbs. full rises only when the queue holds
// QUEUE_DEPTH entries. Reset clears run state, position, queue and result register.
module ascii_token_lexer_unit #(
    parameter int QUEUE_DEPTH = atl_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  byte_value,
    input  logic        end_of_input,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  token_kind,
    output logic [15:0] start_pos,
    output logic [15:0] token_length,
    output logic        last_result
);
    import atl_pkg::*;

    logic       in_take;
    logic       q_push;
    logic       q_pop;
    logic       q_vld;
    logic       q_full;
    atl_entry_t q_wr_entry;
    atl_entry_t q_head;

    assign full    = q_full;
    assign in_take = push && !q_full;

    atl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_take      (in_take),
        .byte_value   (byte_value),
        .end_of_input (end_of_input),
        .q_push       (q_push),
        .q_entry      (q_wr_entry)
    );

    atl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_entry),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .q_vld   (q_vld),
        .q_full  (q_full)
    );

    atl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_vld        (q_vld),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .token_kind   (token_kind),
        .start_pos    (start_pos),
        .token_length (token_length),
        .last_result  (last_result)
    );

`ifndef ASSERT_OFF
    // Front end never writes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("token queue overflow");

    // End token closes its transaction and has zero length
    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && token_kind == KIND_END) |-> (last_result && token_length == 16'd0))
        else $error("malformed end token");

    // Only a run token can be followed by another token of the same item
    a_first_is_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last_result) |-> (token_kind <= KIND_WHITESPACE))
        else $error("non-run token not marked last");
`endif

endmodule

### rtl/core/atl_front.sv
// Front end: classifies each accepted byte, tracks the open run and builds queue entries.
module atl_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_take,
    input  logic [7:0]          byte_value,
    input  logic                end_of_input,
    output logic                q_push,
    output atl_pkg::atl_entry_t q_entry
);
    import atl_pkg::*;

    logic [1:0]  run_kind_reg, run_kind_next;
    logic [15:0] run_start_reg, run_start_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] pos_adv;
    logic [4:0]  kind;
    logic        run_open;
    logic        run_cont;

    // Classify the byte and check whether it extends the open run
    assign kind     = classify(byte_value);
    assign run_open = (run_kind_reg != RUN_NONE);
    assign run_cont = run_open && (kind <= KIND_WHITESPACE)
                      && ((kind[1:0] + 2'd1) == run_kind_reg);
    assign pos_adv  = (pos_reg < POS_LIMIT) ? (pos_reg + 16'd1) : POS_LIMIT;

    // Build the entry and the next run state
    always_comb
    begin
        q_entry.run_vld   = run_open;
        q_entry.run_code  = run_kind_reg - 2'd1;
        q_entry.run_start = run_start_reg;
        q_entry.run_len   = pos_reg - run_start_reg;
        q_entry.own_vld   = 1'b0;
        q_entry.own_kind  = kind;
        q_entry.own_start = pos_reg;
        run_kind_next     = run_kind_reg;
        run_start_next    = run_start_reg;
        pos_next          = pos_reg;
        q_push            = 1'b0;
        if (in_take)
        begin
            if (end_of_input)
            begin
                q_entry.own_vld  = 1'b1;
                q_entry.own_kind = KIND_END;
                q_push           = 1'b1;
                run_kind_next    = RUN_NONE;
                run_start_next   = 16'd0;
                pos_next         = 16'd0;
            end
            else if (run_cont)
            begin
                pos_next = pos_adv;
            end
            else
            begin
                pos_next = pos_adv;
                if (kind <= KIND_WHITESPACE)
                begin
                    run_kind_next  = kind[1:0] + 2'd1;
                    run_start_next = pos_reg;
                    q_push         = run_open;
                end
                else
                begin
                    run_kind_next   = RUN_NONE;
                    q_entry.own_vld = 1'b1;
                    q_push          = 1'b1;
                end
            end
        end
    end

    // Hold run state and byte position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg  <= RUN_NONE;
            run_start_reg <= 16'd0;
            pos_reg       <= 16'd0;
        end
        else
        begin
            run_kind_reg  <= run_kind_next;
            run_start_reg <= run_start_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

### rtl/core/atl_queue.sv
// Small FIFO of token entries between the front end and the back end.
module atl_queue #(
    parameter int DEPTH = atl_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  atl_pkg::atl_entry_t wr_data,
    input  logic                rd_en,
    output atl_pkg::atl_entry_t rd_data,
    output logic                q_vld,
    output logic                q_full
);
    import atl_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    atl_entry_t  mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg;

    assign rd_data = mem[rd_ptr_reg];
    assign q_vld   = (cnt_reg != '0);
    assign q_full  = (cnt_reg == CW'(DEPTH));

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (!wr_en && rd_en)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

### rtl/core/atl_back.sv
// Back end: splits each queue entry into tokens and holds the result register.
module atl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_vld,
    input  atl_pkg::atl_entry_t q_head,
    output logic                q_pop,
    input  logic                pop,
    output logic                empty,
    output logic [4:0]          token_kind,
    output logic [15:0]         start_pos,
    output logic [15:0]         token_length,
    output logic                last_result
);
    import atl_pkg::*;

    logic        out_vld_reg;
    logic        phase_reg, phase_next;
    logic        take;
    logic        emit_run;
    logic [4:0]  kind_next;
    logic [15:0] start_next;
    logic [15:0] len_next;
    logic        last_next;
    logic [4:0]  kind_reg;
    logic [15:0] start_reg;
    logic [15:0] len_reg;
    logic        last_reg;

    // Load a token when the queue holds an entry and the result register is free or being taken
    assign take     = q_vld && (!out_vld_reg || pop);
    assign emit_run = q_head.run_vld && !phase_reg;

    // Pick the run token first, then the entry's own token
    always_comb
    begin
        phase_next = phase_reg;
        q_pop      = 1'b0;
        if (emit_run)
        begin
            kind_next  = {3'b000, q_head.run_code};
            start_next = q_head.run_start;
            len_next   = q_head.run_len;
            last_next  = !q_head.own_vld;
            if (take)
            begin
                q_pop      = !q_head.own_vld;
                phase_next = q_head.own_vld;
            end
        end
        else
        begin
            kind_next  = q_head.own_kind;
            start_next = q_head.own_start;
            len_next   = (q_head.own_kind == KIND_END) ? 16'd0 : 16'd1;
            last_next  = 1'b1;
            if (take)
            begin
                q_pop      = 1'b1;
                phase_next = 1'b0;
            end
        end
    end

    // Hold control state of the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            if (take)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Capture the token payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            kind_reg  <= kind_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            last_reg  <= last_next;
        end
    end

    assign empty        = !out_vld_reg;
    assign token_kind   = kind_reg;
    assign start_pos    = start_reg;
    assign token_length = len_reg;
    assign last_result  = last_reg;

endmodule

### test/tb_ascii_token_lexer_unit.sv
// Self-checking testbench for the ASCII token lexer: directed table and random words.
`timescale 1ns / 1ps

module tb_ascii_token_lexer_unit;

    import atl_pkg::KIND_SYMBOL;
    import atl_pkg::KIND_ERROR;
    import atl_pkg::KIND_END;
    import atl_pkg::KIND_PUNCT_BASE;

    localparam int          RAND_ITEMS = 1050;
    localparam int          CALM_ITEMS = 150;
    localparam int          NUM_DIR    = 25;
    localparam logic [15:0] SAT_POS    = 16'hFFFF;
    localparam int          PUNCT_NUM  = 23;
    // Punctuation bytes in token-kind order, first character in the top byte
    localparam logic [8*PUNCT_NUM-1:0] PUNCT_CHARS = ":,.-/=#@!%*+?&~[]$;()'\"";

    typedef enum logic [1:0] {OPEN_NONE, OPEN_SYMBOL, OPEN_INTEGER, OPEN_SPACE} open_run_t;
    typedef enum int {CL_SYMBOL, CL_DIGIT, CL_SPACE, CL_PUNCT, CL_ANY} byte_class_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
        logic       known;
        token_t     tok;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  byte_value;
    logic        end_of_input;
    logic        empty;
    logic        pop;
    logic [4:0]  token_kind;
    logic [15:0] start_pos;
    logic [15:0] token_length;
    logic        last_result;

    // Lexer shadow state
    open_run_t   open_run;
    logic [15:0] run_begin;
    logic [15:0] next_pos;

    token_t      pending_tokens [$];
    int          mismatches = 0;
    logic        calm_tail  = 1'b0;
    stim_row_t   dir_rows [NUM_DIR];

    ascii_token_lexer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .byte_value   (byte_value),
        .end_of_input (end_of_input),
        .empty        (empty),
        .pop          (pop),
        .token_kind   (token_kind),
        .start_pos    (start_pos),
        .token_length (token_length),
        .last_result  (last_result)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Token kind of one byte: run classes, punctuation or error
    function automatic logic [4:0] kind_of_byte(input logic [7:0] b);
        logic [4:0] kind;
        kind = KIND_ERROR;
        if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_")
            kind = KIND_SYMBOL;
        else if (b >= "0" && b <= "9")
            kind = KIND_SYMBOL + 5'd1;
        else if (b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0B || b == 8'h0C || b == 8'h0D)
            kind = KIND_SYMBOL + 5'd2;
        else
        begin
            for (int i = 0; i < PUNCT_NUM; i++)
            begin
                if (PUNCT_CHARS[8*(PUNCT_NUM-1-i) +: 8] == b)
                    kind = KIND_PUNCT_BASE + 5'(i);
            end
        end
        return kind;
    endfunction

    function automatic token_t run_token();
        token_t t;
        t.kind  = 5'(open_run) - 5'd1;
        t.start = run_begin;
        t.len   = next_pos - run_begin;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic void step_pos();
        if (next_pos < SAT_POS)
            next_pos = next_pos + 16'd1;
    endfunction

    // Advance the shadow lexer by one item; return the number of tokens it emits
    function automatic int lex_step(input logic [7:0] b, input logic e,
                                    output token_t first, output token_t second);
        logic [4:0] kind;
        int         n;
        n      = 0;
        first  = '0;
        second = '0;
        if (e)
        begin
            if (open_run != OPEN_NONE)
            begin
                first = run_token();
                n = 1;
            end
            second = '{KIND_END, next_pos, 16'd0, 1'b1};
            if (n == 0)
                first = second;
            n++;
            open_run  = OPEN_NONE;
            run_begin = '0;
            next_pos  = '0;
            return n;
        end
        kind = kind_of_byte(b);
        // Extend the open run silently
        if (open_run != OPEN_NONE && kind + 5'd1 == 5'(open_run))
        begin
            step_pos();
            return 0;
        end
        // Close the open run first
        if (open_run != OPEN_NONE)
        begin
            first = run_token();
            n = 1;
            open_run = OPEN_NONE;
        end
        if (kind <= KIND_SYMBOL + 5'd2)
        begin
            open_run  = open_run_t'(kind[1:0] + 2'd1);
            run_begin = next_pos;
            step_pos();
            first.last = (n > 0);
            return n;
        end
        if (n == 0)
            first = '{kind, next_pos, 16'd1, 1'b1};
        else
            second = '{kind, next_pos, 16'd1, 1'b1};
        step_pos();
        return n + 1;
    endfunction

    function automatic logic [7:0] pick_class_byte(input byte_class_t cls);
        int r;
        case (cls)
            CL_SYMBOL:
            begin
                r = $urandom_range(0, 52);
                if (r < 26)
                    return 8'("a" + r);
                else if (r < 52)
                    return 8'("A" + r - 26);
                return "_";
            end
            CL_DIGIT:
                return 8'("0" + $urandom_range(0, 9));
            CL_SPACE:
            begin
                r = $urandom_range(0, 5);
                return (r == 5) ? " " : 8'(8'h09 + r);
            end
            CL_PUNCT:
            begin
                r = $urandom_range(0, PUNCT_NUM - 1);
                return PUNCT_CHARS[8*(PUNCT_NUM-1-r) +: 8];
            end
            default:
                return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic stim_row_t plain_row(input logic [7:0] b, input logic e);
        return '{b, e, 1'b0, token_t'('0)};
    endfunction

    function automatic stim_row_t known_row(input logic [7:0] b, input logic e,
                                            input logic [4:0] kind, input logic [15:0] start,
                                            input logic [15:0] len);
        return '{b, e, 1'b1, token_t'{kind, start, len, 1'b1}};
    endfunction

    // Drive one transaction and record the tokens it should produce
    task automatic send_item(input logic [7:0] b, input logic e,
                             input logic known, input token_t known_tok);
        token_t t0;
        token_t t1;
        int     n;
        @(negedge clk);
        push         <= 1'b1;
        byte_value   <= b;
        end_of_input <= e;
        do
            @(posedge clk);
        while (full);
        n = lex_step(b, e, t0, t1);
        if (known)
            pending_tokens.push_back(known_tok);
        else
        begin
            if (n > 0)
                pending_tokens.push_back(t0);
            if (n > 1)
                pending_tokens.push_back(t1);
        end
    endtask

    task automatic hold_off(input int cycles);
        @(negedge clk);
        push <= 1'b0;
        repeat (cycles - 1) @(negedge clk);
    endtask

    task automatic maybe_hold_off();
        if (!calm_tail && $urandom_range(0, 7) == 0)
            hold_off($urandom_range(1, 14));
    endtask

    task automatic drain_tokens();
        while (pending_tokens.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus: directed table, random words
    initial
    begin : stimulus
        byte_class_t cls;
        int          word_len;
        int          sent;
        int          pick;
        logic        paused;
        push         = 1'b0;
        byte_value   = 8'h00;
        end_of_input = 1'b0;
        rst_n        = 1'b0;
        open_run     = OPEN_NONE;
        run_begin    = '0;
        next_pos     = '0;
        paused       = 1'b0;
        dir_rows = '{
            known_row(8'h00, 1'b1, KIND_END,   16'd0,  16'd0),
            known_row(8'h00, 1'b0, KIND_ERROR, 16'd0,  16'd1),
            known_row(8'hFF, 1'b0, KIND_ERROR, 16'd1,  16'd1),
            plain_row("a", 1'b0), plain_row("Z", 1'b0), plain_row("_", 1'b0),
            plain_row("0", 1'b0), plain_row("9", 1'b0),
            plain_row(" ", 1'b0), plain_row(8'h09, 1'b0), plain_row(8'h0A, 1'b0),
            plain_row(8'h0B, 1'b0), plain_row(8'h0C, 1'b0), plain_row(8'h0D, 1'b0),
            plain_row(":", 1'b0), plain_row("\"", 1'b0),
            known_row(8'h7F, 1'b0, KIND_ERROR, 16'd15, 16'd1),
            known_row(8'h80, 1'b0, KIND_ERROR, 16'd16, 16'd1),
            plain_row("z", 1'b0), plain_row("1", 1'b0),
            plain_row(8'h00, 1'b1),
            known_row(8'h00, 1'b1, KIND_END,   16'd0,  16'd0),
            known_row("A",   1'b1, KIND_END,   16'd0,  16'd0),
            plain_row("~", 1'b0),
            plain_row(8'hFF, 1'b1)
        };

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < NUM_DIR; i++)
        begin
            maybe_hold_off();
            send_item(dir_rows[i].b, dir_rows[i].e, dir_rows[i].known, dir_rows[i].tok);
        end
        hold_off(1);
        drain_tokens();

        // Random words: mostly same-class runs, some punctuation, noise and closings
        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            calm_tail = (sent >= RAND_ITEMS - CALM_ITEMS);
            if (!paused && sent >= RAND_ITEMS / 2)
            begin
                hold_off(1);
                drain_tokens();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 19);
            if (pick == 19)
            begin
                maybe_hold_off();
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, '0);
                sent++;
            end
            else
            begin
                if (pick < 6)
                    cls = CL_SYMBOL;
                else if (pick < 10)
                    cls = CL_DIGIT;
                else if (pick < 13)
                    cls = CL_SPACE;
                else if (pick < 16)
                    cls = CL_PUNCT;
                else
                    cls = CL_ANY;
                word_len = (cls == CL_PUNCT || cls == CL_ANY) ? 1 : $urandom_range(1, 6);
                repeat (word_len)
                begin
                    maybe_hold_off();
                    send_item(pick_class_byte(cls), 1'b0, 1'b0, '0);
                    sent++;
                end
            end
        end
        send_item(8'h00, 1'b1, 1'b0, '0);
        @(negedge clk);
        push <= 1'b0;

        // Let the last tokens arrive, then watch for strays
        drain_tokens();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("ascii_token_lexer_unit: match");
        else
            $display("ascii_token_lexer_unit: mismatch");
        $finish;
    end

    // Result side: pop with random stall bursts, none in the calm tail
    initial
    begin : token_sink
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else if (!calm_tail && $urandom_range(0, 11) == 0)
            begin
                pop <= 1'b0;
                stall_left = $urandom_range(0, 13);
            end
            else
                pop <= 1'b1;
        end
    end

    // Compare each popped token with the oldest expected one
    always @(posedge clk)
    begin
        token_t got;
        token_t want;
        if (rst_n && pop && !empty)
        begin
            got = '{token_kind, start_pos, token_length, last_result};
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected token: kind %0d start %0d len %0d last %0d",
                         $time, got.kind, got.start, got.len, got.last);
            end
            else
            begin
                want = pending_tokens.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    $write("%0t: token differs: expected kind %0d start %0d len %0d last %0d,",
                           $time, want.kind, want.start, want.len, want.last);
                    $display(" got kind %0d start %0d len %0d last %0d",
                             got.kind, got.start, got.len, got.last);
                end
            end
        end
    end

    // Guard against a hung handshake
    initial
    begin
        #20_000_000;
        $display("ascii_token_lexer_unit: mismatch");
        $finish;
    end

endmodule
